// File: rtl/u2d_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
`timescale 1ns / 1ps

package u2d_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	// Results caused by one input byte: one or two code points.
	typedef struct packed {
		logic        two;
		logic [15:0] cp0;
		logic [15:0] cp1;
		logic        last;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

// File: rtl/u2d_front.sv
// Front end: tracks the pending sequence and classifies each byte into a job.
`timescale 1ns / 1ps

module u2d_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             in_byte,
	input  logic                   is_last,
	output logic                   push,
	output u2d_pkg::job_t          job
);

	logic [1:0]  pend_q;
	logic [15:0] partial_q;
	logic [1:0]  nxt_pend;
	logic [15:0] nxt_part;
	logic [1:0]  n;
	logic [15:0] cp0;
	logic [15:0] cp1;
	logic        lead;

	always_comb begin
		nxt_pend = pend_q;
		nxt_part = partial_q;
		n        = 2'd0;
		cp0      = '0;
		cp1      = '0;
		lead     = 1'b0;

		if (pend_q != u2d_pkg::PEND_NONE) begin
			if (in_byte[7:6] == 2'b10) begin
				if (pend_q == u2d_pkg::PEND_TWO)
					nxt_part = partial_q | {4'b0, in_byte[5:0], 6'b0};
				else
					nxt_part = partial_q | {10'b0, in_byte[5:0]};
				nxt_pend = pend_q - 2'd1;
				if (nxt_pend == u2d_pkg::PEND_NONE) begin
					cp0      = nxt_part;
					n        = 2'd1;
					nxt_part = '0;
				end
			end else begin
				// broken sequence: flush zero-filled, then reparse as a lead
				cp0      = partial_q;
				n        = 2'd1;
				nxt_pend = u2d_pkg::PEND_NONE;
				nxt_part = '0;
				lead     = 1'b1;
			end
		end else begin
			lead = 1'b1;
		end

		if (lead) begin
			case (in_byte) inside
				8'b0???????: begin
					if (n == 2'd0) cp0 = {8'b0, in_byte};
					else           cp1 = {8'b0, in_byte};
					n = n + 2'd1;
				end
				8'b110?????: begin
					nxt_part = {5'b0, in_byte[4:0], 6'b0};
					nxt_pend = u2d_pkg::PEND_ONE;
				end
				8'b1110????: begin
					nxt_part = {in_byte[3:0], 12'b0};
					nxt_pend = u2d_pkg::PEND_TWO;
				end
				default: begin
					if (n == 2'd0) cp0 = '0;
					else           cp1 = '0;
					n = n + 2'd1;
				end
			endcase
		end

		// end of string mid-sequence
		if (is_last && nxt_pend != u2d_pkg::PEND_NONE) begin
			if (n == 2'd0) cp0 = nxt_part;
			else           cp1 = nxt_part;
			n        = n + 2'd1;
			nxt_pend = u2d_pkg::PEND_NONE;
			nxt_part = '0;
		end
	end

	assign push     = accept && (n != 2'd0);
	assign job.two  = (n == 2'd2);
	assign job.cp0  = cp0;
	assign job.cp1  = cp1;
	assign job.last = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= u2d_pkg::PEND_NONE;
			partial_q <= '0;
		end else if (accept) begin
			pend_q    <= nxt_pend;
			partial_q <= nxt_part;
		end
	end

	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("pending count out of range");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == u2d_pkg::PEND_NONE |-> partial_q == 16'd0)
		else $error("partial value left over with nothing pending");

endmodule

// File: rtl/u2d_queue.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module u2d_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  u2d_pkg::job_t          push_job,
	input  logic                   pop,
	output u2d_pkg::job_t          head,
	output u2d_pkg::queue_status_t status
);

	u2d_pkg::job_t                mem_q [u2d_pkg::QUEUE_DEPTH];
	logic [u2d_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [u2d_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [u2d_pkg::QCNT_W-1:0]  count_q;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == u2d_pkg::QCNT_W'(u2d_pkg::QUEUE_DEPTH));
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.empty |-> !pop)
		else $error("pop from empty queue");

endmodule

// File: rtl/u2d_back.sv
// Back end: walks each job and drives one code point per beat from an output register.
`timescale 1ns / 1ps

module u2d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  u2d_pkg::job_t          head,
	input  u2d_pkg::queue_status_t status,
	output logic                   pop,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [15:0]            code_point,
	output logic                   run_last,
	output logic                   stream_end
);

	logic        sel_q;
	logic        valid_q;
	logic [15:0] cp_q;
	logic        run_last_q;
	logic        end_q;
	logic        load;
	logic        job_done;

	assign load     = !valid_q || !out_stall;
	assign job_done = !head.two || sel_q;
	assign pop      = load && !status.empty && job_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !status.empty;
			if (!status.empty)
				sel_q <= !job_done;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !status.empty) begin
			cp_q       <= sel_q ? head.cp1 : head.cp0;
			run_last_q <= job_done;
			end_q      <= job_done && head.last;
		end
	end

	assign out_valid  = valid_q;
	assign code_point = cp_q;
	assign run_last   = run_last_q;
	assign stream_end = end_q;

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> run_last)
		else $error("stream end without run last");

	a_second_half: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> !status.empty && head.two)
		else $error("second result selected without a two-result job");

endmodule

// File: rtl/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder.
// A byte's first code point passes the job queue, then the output register, to the output.
// Throughput: one byte per cycle; a byte that yields two code points needs two output beats.
// A four-entry job queue lets input run on while the output is stalled; the input stalls when
// the queue is full.
// Reset (arst_n low, asynchronous) clears the pending sequence, the queue and the output valid.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_point,
	output logic        run_last,
	output logic        stream_end
);

	u2d_pkg::job_t          job;
	u2d_pkg::job_t          head;
	u2d_pkg::queue_status_t status;
	logic                   push;
	logic                   pop;
	logic                   accept;

	assign in_stall = status.full;
	assign accept   = in_valid && !status.full;

	u2d_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.is_last (is_last),
		.push    (push),
		.job     (job)
	);

	u2d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.status   (status)
	);

	u2d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.status     (status),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.code_point (code_point),
		.run_last   (run_last),
		.stream_end (stream_end)
	);

endmodule

// File: tb/sv/utf8_decode_checker.sv
// Checker for the UTF-8 decoder: predicts code points from accepted bytes and compares them.
`timescale 1ns / 1ps

module utf8_decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        is_last,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] code_point,
	input  logic        run_last,
	input  logic        stream_end,
	output int          mismatches,
	output int          chars_due
);

	typedef struct packed {
		logic [15:0] cp;
		logic        run_last;
		logic        stream_end;
	} char_beat_t;

	logic [1:0]  cont_left;
	logic [15:0] partial_cp;
	char_beat_t  step_chars[$];
	char_beat_t  expected_chars[$];
	char_beat_t  want;
	int          fail_count = 0;
	int          due_count = 0;

	assign mismatches = fail_count;
	assign chars_due  = due_count;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] exp_val);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
		fail_count++;
	endtask

	function automatic void emit_char(input logic [15:0] cp);
		char_beat_t beat;
		beat.cp         = cp;
		beat.run_last   = 1'b0;
		beat.stream_end = 1'b0;
		step_chars = {step_chars, beat};
	endfunction

	function automatic void take_lead(input logic [7:0] b);
		if (!b[7]) begin
			emit_char({8'h00, b});
		end else if (b[7:5] == 3'b110) begin
			partial_cp = {5'b0, b[4:0], 6'b0};
			cont_left  = u2d_pkg::PEND_ONE;
		end else if (b[7:4] == 4'b1110) begin
			partial_cp = {b[3:0], 12'b0};
			cont_left  = u2d_pkg::PEND_TWO;
		end else begin
			// stray continuation or a lead of four bytes and up
			emit_char(16'h0000);
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		step_chars.delete();
		if (cont_left != u2d_pkg::PEND_NONE) begin
			if (b[7:6] == 2'b10) begin
				partial_cp = partial_cp |
					({10'b0, b[5:0]} << ((cont_left == u2d_pkg::PEND_TWO) ? 6 : 0));
				cont_left = cont_left - 2'd1;
				if (cont_left == u2d_pkg::PEND_NONE) begin
					emit_char(partial_cp);
					partial_cp = '0;
				end
			end else begin
				// sequence broken off: flush zero-filled, then treat byte as a new lead
				emit_char(partial_cp);
				cont_left  = u2d_pkg::PEND_NONE;
				partial_cp = '0;
				take_lead(b);
			end
		end else begin
			take_lead(b);
		end
		if (last && cont_left != u2d_pkg::PEND_NONE) begin
			emit_char(partial_cp);
			cont_left  = u2d_pkg::PEND_NONE;
			partial_cp = '0;
		end
		if (step_chars.size() > 0) begin
			step_chars[step_chars.size() - 1].run_last   = 1'b1;
			step_chars[step_chars.size() - 1].stream_end = last;
		end
		expected_chars = {expected_chars, step_chars};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_left  = u2d_pkg::PEND_NONE;
			partial_cp = '0;
			expected_chars.delete();
			due_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("unexpected beat", code_point, 16'h0000);
				end else begin
					want = expected_chars.pop_front();
					if (code_point !== want.cp)
						report_mismatch("code_point", code_point, want.cp);
					if (run_last !== want.run_last)
						report_mismatch("run_last", {15'b0, run_last}, {15'b0, want.run_last});
					if (stream_end !== want.stream_end)
						report_mismatch("stream_end", {15'b0, stream_end},
							{15'b0, want.stream_end});
				end
			end
			if (in_valid && !in_stall) decode_byte(in_byte, is_last);
			due_count = expected_chars.size();
		end
	end

endmodule

// File: tb/sv/utf8_to_ucs2_decoder_test.sv
// Testbench top for the UTF-8 decoder: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder_test;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 650;
	localparam int HOLD_CYCLES  = 60;

	typedef enum {
		CH_ASCII,
		CH_TWO,
		CH_THREE,
		CH_STRAY,
		CH_HIGH_LEAD,
		CH_BROKEN,
		CH_NOISE
	} char_kind_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        is_last;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] code_point;
	logic        run_last;
	logic        stream_end;

	int          mismatches;
	int          chars_due;
	int          cycle_count = 0;
	int          bytes_sent = 0;
	int          holds_asked = 0;
	int          holds_done = 0;
	bit          gaps_on = 1'b1;
	logic [7:0]  line_bytes[$];

	utf8_to_ucs2_decoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.run_last   (run_last),
		.stream_end (stream_end)
	);

	utf8_decode_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.run_last   (run_last),
		.stream_end (stream_end),
		.mismatches (mismatches),
		.chars_due  (chars_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Output side: random stalls, plus a long hold-off whenever one is asked for.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_stall <= gaps_on && ($urandom_range(0, 99) < 17);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while (gaps_on && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			in_byte  <= 8'($urandom);
			is_last  <= 1'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		is_last  <= last;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	function automatic void queue_byte(input logic [7:0] b);
		line_bytes = {line_bytes, b};
	endfunction

	function automatic char_kind_t pick_kind();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 25) return CH_ASCII;
		if (roll < 50) return CH_TWO;
		if (roll < 75) return CH_THREE;
		if (roll < 80) return CH_STRAY;
		if (roll < 85) return CH_HIGH_LEAD;
		if (roll < 95) return CH_BROKEN;
		return CH_NOISE;
	endfunction

	// One string of random characters, is_last on its final byte.
	task automatic send_line();
		int n_chars;
		n_chars = $urandom_range(1, 12);
		line_bytes.delete();
		repeat (n_chars) begin
			case (pick_kind())
				CH_ASCII: begin
					queue_byte({1'b0, 7'($urandom)});
				end
				CH_TWO: begin
					queue_byte({3'b110, 5'($urandom)});
					queue_byte(cont_byte());
				end
				CH_THREE: begin
					queue_byte({4'b1110, 4'($urandom)});
					queue_byte(cont_byte());
					queue_byte(cont_byte());
				end
				CH_STRAY: begin
					queue_byte(cont_byte());
				end
				CH_HIGH_LEAD: begin
					queue_byte({4'b1111, 4'($urandom)});
				end
				CH_BROKEN: begin
					// lead with too few continuations; next byte or string end cuts it
					if ($urandom_range(0, 1)) begin
						queue_byte({3'b110, 5'($urandom)});
					end else begin
						queue_byte({4'b1110, 4'($urandom)});
						if ($urandom_range(0, 1)) queue_byte(cont_byte());
					end
				end
				default: begin
					queue_byte(8'($urandom));
				end
			endcase
		end
		foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
	endtask

	initial begin
		logic [8:0] warmup[$];
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_byte  = 8'h00;
		is_last  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// {is_last, byte}
		warmup = '{
			9'h000, 9'h17F,                 // lowest ascii, highest ascii ending a string
			9'h0C2, 9'h0A9,                 // two-byte character
			9'h0C0, 9'h080,                 // two-byte lead with all-zero payload
			9'h0EF, 9'h0BF, 9'h0BF,         // largest three-byte character
			9'h080,                         // stray continuation
			9'h0F0, 9'h0FF,                 // leads of four bytes and up
			9'h0C3, 9'h041,                 // two-byte broken by ascii
			9'h0E0, 9'h0A0, 9'h0F8,         // three-byte broken by an invalid lead
			9'h0E4, 9'h0C5, 9'h1B8,         // broken by a new lead that completes at the end
			9'h1E4,                         // string ends right on a three-byte lead
			9'h0ED, 9'h1A0,                 // string ends one continuation short
			9'h1C5                          // string ends on a two-byte lead
		};
		foreach (warmup[i]) send_byte(warmup[i][7:0], warmup[i][8]);

		while (bytes_sent < 250) send_line();

		// output held off while input keeps coming, so the job queue fills up
		holds_asked++;
		repeat (3) send_line();

		gaps_on = 1'b0;
		while (bytes_sent < 450) send_line();
		gaps_on = 1'b1;
		holds_asked++;
		while (bytes_sent < RANDOM_BYTES) send_line();

		in_valid <= 1'b0;
		while (chars_due != 0) @(negedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: utf8_to_ucs2_decoder.f
rtl/u2d_pkg.sv
rtl/u2d_front.sv
rtl/u2d_queue.sv
rtl/u2d_back.sv
rtl/utf8_to_ucs2_decoder.sv
tb/sv/utf8_decode_checker.sv
tb/sv/utf8_to_ucs2_decoder_test.sv
